// ===== hdl/itchfp_pkg.sv =====
package itchfp_pkg;

  localparam int NUM_KINDS  = 23;
  localparam int MAX_FIELDS = 17;
  localparam int MAX_PUSH   = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MPID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_LENGTH = 2'd1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;

  localparam logic [4:0] KIND_ADD_ATTR = 5'd10;
  localparam logic [4:0] KIND_EXEC     = 5'd12;
  localparam logic [4:0] KIND_DELETE   = 5'd15;

  localparam logic [4:0] FLD_MPID      = 5'd8;
  localparam logic [4:0] FLD_PRINTABLE = 5'd6;
  localparam logic [4:0] FLD_EXEC_PX   = 5'd7;
  localparam logic [4:0] FLD_CANCELLED = 5'd4;

  localparam logic [7:0] PRINTABLE_YES = 8'h59;

  typedef struct packed {
    logic [4:0]  message_kind;
    logic [4:0]  field_number;
    logic [63:0] field_value;
    logic        field_defaulted;
    logic        last_of_message;
    logic [1:0]  error_code;
  } result_t;

  typedef logic [3:0] fw_row_t [0:MAX_FIELDS-1];

  localparam fw_row_t FIELD_WIDTH [0:NUM_KINDS-1] = '{
    '{2,2,6,1,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,1,4,1,1,2,1,1,1,1,1,4,1},
    '{2,2,6,8,1,1,4,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,4,8,1,1,1,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,8,8,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,1,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,4,1,4,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,4,4,4,4,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,1,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,4,8,4,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,4,8,4,4,0,0,0,0,0,0,0,0},
    '{2,2,6,8,4,8,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,4,8,1,4,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,4,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,8,4,4,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,4,8,4,8,0,0,0,0,0,0,0,0},
    '{2,2,6,8,8,4,8,1,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,8,1,8,4,4,4,1,1,0,0,0,0,0},
    '{2,2,6,8,1,0,0,0,0,0,0,0,0,0,0,0,0},
    '{2,2,6,8,1,4,4,4,8,4,4,0,0,0,0,0,0}
  };

  localparam logic [4:0] FIELD_COUNT [0:NUM_KINDS-1] = '{
    4, 17, 7, 5, 8, 6, 4, 7, 8, 6, 8, 9, 6, 8, 5, 4, 7, 9, 8, 4, 12, 5, 11
  };

  localparam logic [5:0] CANON_LEN [0:NUM_KINDS-1] = '{
    12, 39, 25, 20, 26, 35, 12, 28, 35, 21, 36, 40, 31, 36, 23, 19, 35, 44, 40, 19,
    50, 20, 48
  };

  localparam logic [7:0] TYPE_CODE [0:NUM_KINDS-1] = '{
    "S","R","H","Y","L","V","W","K","J","h","A","F","E","C","X","D","U","P","Q","B",
    "I","N","O"
  };

  function automatic logic [5:0] type_lookup(input logic [7:0] code);
    logic [5:0] res;
    res = '0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (TYPE_CODE[k] == code) begin
        res = {1'b1, 5'(k)};
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/itchfp_byte_if.sv =====
interface itchfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/itchfp_result_if.sv =====
interface itchfp_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  message_kind;
  logic [4:0]  field_number;
  logic [63:0] field_value;
  logic        field_defaulted;
  logic        last_of_message;
  logic [1:0]  error_code;

  modport source (output valid, output message_kind, output field_number,
                  output field_value, output field_defaulted, output last_of_message,
                  output error_code, input ready);
  modport sink (input valid, input message_kind, input field_number,
                input field_value, input field_defaulted, input last_of_message,
                input error_code, output ready);
endinterface

// ===== hdl/itchfp_cfg_if.sv =====
interface itchfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/itchfp_result_fifo.sv =====
module itchfp_result_fifo
  import itchfp_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  result_t             push_data [0:MAX_PUSH-1],
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [0:DEPTH-1];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_data  = mem[rptr];
  assign has_room  = count <= CW'(DEPTH - MAX_PUSH);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < push_n) begin
        mem[wptr + PW'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(push_n);
      rptr  <= rptr + PW'(pop);
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("result buffer count exceeds depth");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> has_room)
    else $error("results pushed without room");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 count == $past(count) + CW'($past(push_n)) - CW'($past(pop)))
    else $error("result buffer count out of step");

endmodule

// ===== hdl/itch_message_field_parser_core.sv =====
// A field is written into the result buffer when its last byte is taken, and is offered from there.
// Throughput: one feed byte per cycle; a message end with filled-in fields adds up to two
// extra results, absorbed by an eight-entry result buffer that deasserts feed ready when
// fewer than three entries are free.
// Reset: synchronous active-high rst clears the parser state, the sticky error and the
// buffer; default_mpid resets to 0 and check_length to 1.
module itch_message_field_parser_core
  import itchfp_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  itchfp_byte_if.sink   feed,
  itchfp_result_if.source result,
  itchfp_cfg_if.sink    cfg
);

  typedef enum logic [1:0] {PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_BODY} phase_t;

  phase_t      phase;
  logic [15:0] header_length;
  logic [4:0]  current_kind;
  logic [4:0]  current_field;
  logic [3:0]  field_byte_count;
  logic [63:0] field_accumulator;
  logic        error_latched;
  logic [31:0] default_mpid;
  logic        check_length;

  logic        accept;
  logic        has_room;
  logic [1:0]  push_n;
  result_t     push_data [0:MAX_PUSH-1];
  result_t     head;
  logic [5:0]  lookup;
  logic [63:0] acc_next;
  logic [3:0]  fbc_next;
  logic        field_done;
  logic        field_last;
  logic        has_default;

  assign feed.ready = has_room;
  assign cfg.ready  = 1'b1;
  assign accept     = feed.valid && feed.ready;

  assign lookup      = type_lookup(feed.data_byte);
  assign acc_next    = {field_accumulator[55:0], feed.data_byte};
  assign fbc_next    = field_byte_count + 4'd1;
  assign field_done  = fbc_next == FIELD_WIDTH[current_kind][current_field];
  assign field_last  = (current_field + 5'd1) == FIELD_COUNT[current_kind];
  assign has_default = current_kind == KIND_ADD_ATTR || current_kind == KIND_EXEC ||
                       current_kind == KIND_DELETE;

  always_comb begin
    push_n = 2'd0;
    for (int i = 0; i < MAX_PUSH; i++) begin
      push_data[i] = '{message_kind: current_kind, field_number: '0, field_value: '0,
                       field_defaulted: 1'b1, last_of_message: 1'b1, error_code: ERR_NONE};
    end
    if (accept && !error_latched) begin
      case (phase)
        PH_TYPE: begin
          if (!lookup[5]) begin
            push_n = 2'd1;
            push_data[0] = '{message_kind: '0, field_number: '0,
                             field_value: {56'd0, feed.data_byte}, field_defaulted: 1'b0,
                             last_of_message: 1'b1, error_code: ERR_UNKNOWN};
          end else if (check_length &&
                       header_length != {10'd0, CANON_LEN[lookup[4:0]]}) begin
            push_n = 2'd1;
            push_data[0] = '{message_kind: lookup[4:0], field_number: '0,
                             field_value: {48'd0, header_length}, field_defaulted: 1'b0,
                             last_of_message: 1'b1, error_code: ERR_MISMATCH};
          end
        end
        PH_BODY: begin
          if (field_done) begin
            push_n = 2'd1;
            push_data[0] = '{message_kind: current_kind, field_number: current_field,
                             field_value: acc_next, field_defaulted: 1'b0,
                             last_of_message: field_last && !has_default,
                             error_code: ERR_NONE};
            if (field_last) begin
              case (current_kind)
                KIND_ADD_ATTR: begin
                  push_n = 2'd2;
                  push_data[1].field_number = FLD_MPID;
                  push_data[1].field_value  = {32'd0, default_mpid};
                end
                KIND_EXEC: begin
                  push_n = 2'd3;
                  push_data[1].field_number    = FLD_PRINTABLE;
                  push_data[1].field_value     = {56'd0, PRINTABLE_YES};
                  push_data[1].last_of_message = 1'b0;
                  push_data[2].field_number    = FLD_EXEC_PX;
                end
                KIND_DELETE: begin
                  push_n = 2'd2;
                  push_data[1].field_number = FLD_CANCELLED;
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN_HI;
      header_length     <= '0;
      current_kind      <= '0;
      current_field     <= '0;
      field_byte_count  <= '0;
      field_accumulator <= '0;
      error_latched     <= 1'b0;
      default_mpid      <= '0;
      check_length      <= 1'b1;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEFAULT_MPID: default_mpid <= cfg.data;
          REG_CHECK_LENGTH: check_length <= cfg.data[0];
          default: begin
          end
        endcase
      end
      if (accept && !error_latched) begin
        case (phase)
          PH_LEN_HI: begin
            header_length <= {feed.data_byte, 8'd0};
            phase         <= PH_LEN_LO;
          end
          PH_LEN_LO: begin
            header_length <= {header_length[15:8], feed.data_byte};
            phase         <= PH_TYPE;
          end
          PH_TYPE: begin
            phase <= PH_LEN_HI;
            if (!lookup[5] || (check_length &&
                header_length != {10'd0, CANON_LEN[lookup[4:0]]})) begin
              error_latched <= 1'b1;
            end else begin
              current_kind      <= lookup[4:0];
              current_field     <= '0;
              field_byte_count  <= '0;
              field_accumulator <= '0;
              phase             <= PH_BODY;
            end
          end
          default: begin
            if (field_done) begin
              field_accumulator <= '0;
              field_byte_count  <= '0;
              if (field_last) begin
                current_field <= '0;
                phase         <= PH_LEN_HI;
              end else begin
                current_field <= current_field + 5'd1;
              end
            end else begin
              field_accumulator <= acc_next;
              field_byte_count  <= fbc_next;
            end
          end
        endcase
      end
    end
  end

  itchfp_result_fifo #(
    .DEPTH(DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .has_room  (has_room),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (head)
  );

  assign result.message_kind    = head.message_kind;
  assign result.field_number    = head.field_number;
  assign result.field_value     = head.field_value;
  assign result.field_defaulted = head.field_defaulted;
  assign result.last_of_message = head.last_of_message;
  assign result.error_code      = head.error_code;

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("error flag cleared without reset");
  a_no_push_after_err: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> push_n == 2'd0)
    else $error("result produced after error");
  a_field_in_layout: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> current_field < FIELD_COUNT[current_kind])
    else $error("field index beyond layout");

endmodule

// ===== tb/itchfp_tb_pkg.sv =====
package itchfp_tb_pkg;

  localparam int N_KINDS = 23;

  // One row per message kind, one nibble per field width, field zero in the top nibble.
  localparam logic [67:0] WIDTH_ROW [0:N_KINDS-1] = '{
    68'h22610000000000000, 68'h22681141121111141, 68'h22681140000000000,
    68'h22681000000000000, 68'h22648111000000000, 68'h22688800000000000,
    68'h22610000000000000, 68'h22684140000000000, 68'h22684444000000000,
    68'h22681100000000000, 68'h22681484000000000, 68'h22681484400000000,
    68'h22684800000000000, 68'h22684814000000000, 68'h22684000000000000,
    68'h22680000000000000, 68'h22688440000000000, 68'h22681484800000000,
    68'h22688481000000000, 68'h22680000000000000, 68'h22688184441100000,
    68'h22681000000000000, 68'h22681444844000000
  };

  localparam logic [8*N_KINDS-1:0] KIND_CODES = "SRHYLVWKJhAFECXDUPQBINO";

  function automatic logic [3:0] width_of(input int k, input int f);
    logic [67:0] row;
    row = WIDTH_ROW[k];
    return row[67-4*f -: 4];
  endfunction

  function automatic int fields_in(input int k);
    int n;
    n = 0;
    while (n < 17 && width_of(k, n) != 0) n++;
    return n;
  endfunction

  function automatic logic [15:0] msg_length(input int k);
    int s;
    s = 1;
    for (int f = 0; f < 17; f++) s += width_of(k, f);
    return 16'(s);
  endfunction

  function automatic logic [7:0] code_of(input int k);
    return KIND_CODES[8*(N_KINDS-1-k) +: 8];
  endfunction

  function automatic int kind_of(input logic [7:0] b);
    int r;
    r = -1;
    for (int k = 0; k < N_KINDS; k++) if (code_of(k) == b) r = k;
    return r;
  endfunction

endpackage

// ===== tb/itchfp_checker.sv =====
module itchfp_checker
  import itchfp_pkg::*;
  import itchfp_tb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  itchfp_byte_if   feed,
  itchfp_result_if result,
  itchfp_cfg_if    cfg,
  output int       errors,
  output int       pending
);

  result_t     field_q[$];
  logic [31:0] mpid;
  logic        chk_len;
  int          byte_pos;
  logic [15:0] hdr_len;
  int          cur_kind;
  int          cur_field;
  int          fbytes;
  logic [63:0] acc;
  logic        halted;

  function automatic void push_field(input int k, input int f, input logic [63:0] v,
                                     input logic d, input logic l, input logic [1:0] e);
    result_t r;
    r.message_kind    = 5'(k);
    r.field_number    = 5'(f);
    r.field_value     = v;
    r.field_defaulted = d;
    r.last_of_message = l;
    r.error_code      = e;
    field_q.push_back(r);
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    int  k;
    logic last;
    logic has_dflt;
    if (halted) return;
    case (byte_pos)
      0: begin
        hdr_len[15:8] = b;
        byte_pos = 1;
      end
      1: begin
        hdr_len[7:0] = b;
        byte_pos = 2;
      end
      2: begin
        k = kind_of(b);
        byte_pos = 0;
        if (k < 0) begin
          push_field(0, 0, 64'(b), 1'b0, 1'b1, ERR_UNKNOWN);
          halted = 1'b1;
        end else if (chk_len && hdr_len != msg_length(k)) begin
          push_field(k, 0, 64'(hdr_len), 1'b0, 1'b1, ERR_MISMATCH);
          halted = 1'b1;
        end else begin
          cur_kind = k;
          cur_field = 0;
          fbytes = 0;
          acc = '0;
          byte_pos = 3;
        end
      end
      default: begin
        acc = {acc[55:0], b};
        fbytes++;
        if (fbytes == width_of(cur_kind, cur_field)) begin
          last = (cur_field + 1 == fields_in(cur_kind));
          has_dflt = (cur_kind == KIND_ADD_ATTR || cur_kind == KIND_EXEC ||
                      cur_kind == KIND_DELETE);
          push_field(cur_kind, cur_field, acc, 1'b0, last && !has_dflt, ERR_NONE);
          acc = '0;
          fbytes = 0;
          if (!last) begin
            cur_field++;
          end else begin
            if (cur_kind == KIND_ADD_ATTR) begin
              push_field(cur_kind, FLD_MPID, 64'(mpid), 1'b1, 1'b1, ERR_NONE);
            end else if (cur_kind == KIND_EXEC) begin
              push_field(cur_kind, FLD_PRINTABLE, 64'(PRINTABLE_YES), 1'b1, 1'b0, ERR_NONE);
              push_field(cur_kind, FLD_EXEC_PX, 64'd0, 1'b1, 1'b1, ERR_NONE);
            end else if (cur_kind == KIND_DELETE) begin
              push_field(cur_kind, FLD_CANCELLED, 64'd0, 1'b1, 1'b1, ERR_NONE);
            end
            cur_field = 0;
            byte_pos = 0;
          end
        end
      end
    endcase
  endtask

  task automatic compare_field();
    result_t want;
    result_t got;
    got.message_kind    = result.message_kind;
    got.field_number    = result.field_number;
    got.field_value     = result.field_value;
    got.field_defaulted = result.field_defaulted;
    got.last_of_message = result.last_of_message;
    got.error_code      = result.error_code;
    if (field_q.size() == 0) begin
      $display("%0t: unexpected request, actual %p", $time, got);
      errors++;
    end else begin
      want = field_q.pop_front();
      if (got.message_kind !== want.message_kind) begin
        $display("%0t: message_kind expected %0d actual %0d", $time,
                 want.message_kind, got.message_kind);
        errors++;
      end
      if (got.field_number !== want.field_number) begin
        $display("%0t: field_number expected %0d actual %0d", $time,
                 want.field_number, got.field_number);
        errors++;
      end
      if (got.field_value !== want.field_value) begin
        $display("%0t: field_value expected %h actual %h", $time,
                 want.field_value, got.field_value);
        errors++;
      end
      if (got.field_defaulted !== want.field_defaulted) begin
        $display("%0t: field_defaulted expected %b actual %b", $time,
                 want.field_defaulted, got.field_defaulted);
        errors++;
      end
      if (got.last_of_message !== want.last_of_message) begin
        $display("%0t: last_of_message expected %b actual %b", $time,
                 want.last_of_message, got.last_of_message);
        errors++;
      end
      if (got.error_code !== want.error_code) begin
        $display("%0t: error_code expected %0d actual %0d", $time,
                 want.error_code, got.error_code);
        errors++;
      end
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      field_q.delete();
      mpid = '0;
      chk_len = 1'b1;
      byte_pos = 0;
      hdr_len = '0;
      cur_kind = 0;
      cur_field = 0;
      fbytes = 0;
      acc = '0;
      halted = 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_DEFAULT_MPID) mpid = cfg.data;
        else if (cfg.index == REG_CHECK_LENGTH) chk_len = cfg.data[0];
      end
      if (result.valid && result.ready) compare_field();
      if (feed.valid && feed.ready) parse_byte(feed.data_byte);
    end
    pending <= field_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import itchfp_pkg::*;
  import itchfp_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   burst_left;
  int   sent;
  logic hold_req;
  logic chk_on;
  int   ready_mode;
  int   mode_left;

  itchfp_byte_if   feed_if();
  itchfp_result_if result_if();
  itchfp_cfg_if    cfg_if();

  itch_message_field_parser_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  itchfp_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed_if),
    .result  (result_if),
    .cfg     (cfg_if),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    result_if.ready = 1'b0;
    mode_left = 0;
    ready_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_if.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (ready_mode)
          0: result_if.ready = 1'b1;
          1: result_if.ready = $urandom_range(0, 1);
          default: result_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        feed_if.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    feed_if.valid = 1'b1;
    feed_if.data_byte = b;
    do @(posedge clk); while (!feed_if.ready);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    feed_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    if (idx == REG_CHECK_LENGTH) chk_on = val[0];
  endtask

  task automatic send_msg(input int k, input int pat, input logic [15:0] len);
    int n;
    logic [7:0] b;
    n = msg_length(k) - 1;
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(code_of(k));
    for (int i = 0; i < n; i++) begin
      case (pat)
        1: b = 8'h00;
        2: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  function automatic logic [15:0] pick_len(input int k);
    return chk_on ? msg_length(k) : 16'($urandom);
  endfunction

  initial begin
    logic [7:0] tb_code;
    int k;
    int phase;
    rst = 1'b1;
    hold_req = 1'b0;
    chk_on = 1'b1;
    burst_left = 0;
    sent = 0;
    feed_if.valid = 1'b0;
    feed_if.data_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    write_reg(REG_DEFAULT_MPID, 32'hFFFF_FFFF);
    send_msg(KIND_ADD_ATTR, 2, msg_length(KIND_ADD_ATTR));
    write_reg(REG_DEFAULT_MPID, 32'h0);
    write_reg(REG_CHECK_LENGTH, 32'h0);
    send_msg(KIND_ADD_ATTR, 0, 16'hFFFF);
    send_msg(KIND_EXEC, 0, 16'h0000);
    send_msg(KIND_DELETE, 0, 16'($urandom));
    write_reg(REG_SPARE, 32'($urandom));

    phase = 0;
    while (sent < 470) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_DEFAULT_MPID, 32'h0);
        1: write_reg(REG_DEFAULT_MPID, 32'hFFFF_FFFF);
        default: write_reg(REG_DEFAULT_MPID, 32'($urandom));
      endcase
      write_reg(REG_CHECK_LENGTH, 32'($urandom_range(0, 1)));
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(3, 6)) begin
        k = $urandom_range(0, N_KINDS - 1);
        send_msg(k, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0, pick_len(k));
      end
      phase++;
    end

    // The sticky error can only be provoked once, so it closes the run.
    if ($urandom_range(0, 1) == 0) begin
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      do tb_code = 8'($urandom); while (kind_of(tb_code) >= 0);
      send_byte(tb_code);
    end else begin
      write_reg(REG_CHECK_LENGTH, 32'h1);
      k = $urandom_range(0, N_KINDS - 1);
      send_msg(k, 0, msg_length(k) + 16'($urandom_range(1, 300)));
    end
    repeat (10) send_byte(8'($urandom));
    feed_if.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
